@@ rtl/assert_macros.svh @@
// Assertion macros used by the bound checker module vwa_sva.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define VWA_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define VWA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/vwa_pkg.sv @@
`timescale 1ns / 1ps

package vwa_pkg;

	localparam int unsigned FRAC_BITS_DEF = 16;
	localparam int unsigned COEF_COUNT    = 12;

	// Input item codes.
	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_POINT = 1'b1;

	// Configuration register indexes.
	localparam logic [2:0] REG_STIFFNESS    = 3'd0;
	localparam logic [2:0] REG_NORMAL_SCALE = 3'd1;
	localparam logic [2:0] REG_SCALE_FIRST  = 3'd2;

	// Operand A sources: coefficients, temporaries, accumulated sums.
	localparam int A_COEF0 = 0;
	localparam int A_TMP0  = 12;
	localparam int A_SUM0  = 21;

	// Temporary slots: transformed point, transformed normal, cross product.
	localparam int T_PT0 = 0;
	localparam int T_NT0 = 3;
	localparam int T_C0  = 6;

	// Operand B sources.
	localparam int B_P0     = 0;
	localparam int B_N0     = 3;
	localparam int B_NS0    = 5;
	localparam int B_STIFF  = 8;
	localparam int B_NSCALE = 9;
	localparam int B_ONE    = 10;
	localparam int B_SCALE0 = 11;

	// Program layout.
	localparam logic [5:0] PC_PT_BEGIN  = 6'd0;
	localparam logic [5:0] PC_PT_END    = 6'd32;
	localparam logic [5:0] PC_OUT_BEGIN = 6'd33;
	localparam logic [5:0] PC_OUT_END   = 6'd38;

	typedef struct packed {
		logic               cmd;
		logic [3:0]         coeff_index;
		logic signed [31:0] coeff_value;
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
		logic signed [31:0] point_z;
		logic signed [31:0] nrm_x;
		logic signed [31:0] nrm_y;
		logic               point_valid;
		logic               last;
	} vwa_in_t;

	typedef struct packed {
		logic signed [47:0] force_x;
		logic signed [47:0] force_y;
		logic signed [47:0] force_z;
		logic signed [47:0] torque_x;
		logic signed [47:0] torque_y;
		logic signed [47:0] torque_z;
	} vwa_out_t;

	typedef enum logic [1:0] {MD_ROW, MD_SCALE, MD_SUM, MD_OUT} mode_t;
	typedef enum logic [1:0] {S_IDLE, S_PT, S_WAIT_OUT, S_OUT} state_t;
	typedef enum logic [1:0] {PH_LO, PH_HI, PH_WB} phase_t;

	typedef struct packed {
		logic [4:0] a_src;
		logic [4:0] b_src;
		mode_t      md;
		logic       clr;
		logic       neg;
		logic       wr;
		logic [3:0] dst;
	} step_t;

	typedef struct packed {
		logic       ready;
		logic       run;
		phase_t     ph;
		logic [5:0] pc;
		logic       fin;
	} ctl_t;

	// Micro-program: one multiply per step.
	function automatic step_t vwa_step(input logic [5:0] pc);
		step_t s;
		int p;
		int i;
		int j;
		int k1;
		int k2;
		int a;
		int b;
		int d;
		s = '0;
		p = int'(pc);
		a = 0;
		b = 0;
		d = 0;
		s.md = MD_ROW;
		if (p < 12) begin
			// Point rows: translation first, then three rotation terms.
			i = p / 4;
			j = p % 4;
			if (j == 0) begin
				a = A_COEF0 + 9 + i;
				b = B_ONE;
				s.clr = 1'b1;
			end else begin
				a = A_COEF0 + 3 * i + j - 1;
				b = B_P0 + j - 1;
				s.wr = (j == 3);
			end
			d = T_PT0 + i;
		end else if (p < 18) begin
			// Normal rows: two terms, z of the normal is zero.
			i = (p - 12) / 2;
			j = (p - 12) % 2;
			a = A_COEF0 + 3 * i + j;
			b = B_N0 + j;
			s.clr = (j == 0);
			s.wr = (j == 1);
			d = T_NT0 + i;
		end else if (p < 21) begin
			i = p - 18;
			a = A_TMP0 + T_NT0 + i;
			b = B_NSCALE;
			s.md = MD_SCALE;
			s.wr = 1'b1;
			d = i;
		end else if (p < 27) begin
			// Cross product of point and scaled normal.
			i = (p - 21) / 2;
			j = (p - 21) % 2;
			k1 = (i == 2) ? 0 : i + 1;
			k2 = (i == 0) ? 2 : i - 1;
			if (j == 0) begin
				a = A_TMP0 + T_PT0 + k1;
				b = B_NS0 + k2;
				s.clr = 1'b1;
			end else begin
				a = A_TMP0 + T_PT0 + k2;
				b = B_NS0 + k1;
				s.neg = 1'b1;
				s.wr = 1'b1;
			end
			d = T_C0 + i;
		end else if (p < 33) begin
			i = p - 27;
			a = (i < 3) ? A_TMP0 + T_PT0 + i : A_TMP0 + T_C0 + i - 3;
			b = B_STIFF;
			s.md = MD_SUM;
			d = i;
		end else begin
			i = p - 33;
			a = A_SUM0 + i;
			b = B_SCALE0 + i;
			s.md = MD_OUT;
			d = i;
		end
		s.a_src = 5'(a);
		s.b_src = 5'(b);
		s.dst = 4'(d);
		return s;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
		if (&v[65:31] || ~|v[65:31]) begin
			return v[31:0];
		end
		return v[65] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
	endfunction

	function automatic logic signed [63:0] sat64(input logic signed [65:0] v);
		if (&v[65:63] || ~|v[65:63]) begin
			return v[63:0];
		end
		return v[65] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
	endfunction

	function automatic logic signed [47:0] sat48(input logic signed [95:0] v);
		if (&v[95:47] || ~|v[95:47]) begin
			return v[47:0];
		end
		return v[95] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
	endfunction

endpackage

@@ rtl/vwa_mul.sv @@
`timescale 1ns / 1ps

module vwa_mul (
	input  logic                clk,
	input  vwa_pkg::phase_t     ph,
	input  logic signed [63:0]  a,
	input  logic signed [31:0]  b,
	output logic signed [95:0]  prod
);
	import vwa_pkg::*;

	logic signed [32:0] ma;
	logic signed [64:0] m;
	logic signed [64:0] lo_q;
	logic signed [63:0] hi_q;

	// One 33x32 multiplier: low word of a first, then the high word.
	assign ma = (ph == PH_LO) ? $signed({1'b0, a[31:0]}) : $signed({a[63], a[63:32]});
	assign m  = ma * b;

	always_ff @(posedge clk) begin
		if (ph == PH_LO) begin
			lo_q <= m;
		end
		if (ph == PH_HI) begin
			hi_q <= m[63:0];
		end
	end

	// Recombine the two partial products into the exact product.
	assign prod = $signed({hi_q, 32'd0}) + $signed({{31{lo_q[64]}}, lo_q});

endmodule

@@ rtl/vwa_seq.sv @@
`timescale 1ns / 1ps

module vwa_seq (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_take,
	input  logic          in_pt,
	input  logic          in_last,
	input  logic          out_busy,
	output vwa_pkg::ctl_t ctl
);
	import vwa_pkg::*;

	state_t     state_q, state_d;
	phase_t     ph_q, ph_d;
	logic [5:0] pc_q, pc_d;
	logic       last_q;
	logic       step_end;

	assign step_end = (ph_q == PH_WB);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ph_q    <= PH_LO;
			pc_q    <= PC_PT_BEGIN;
			last_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			ph_q    <= ph_d;
			pc_q    <= pc_d;
			if (in_take) begin
				last_q <= in_last;
			end
		end
	end

	// Next state, step counter and phase.
	always_comb begin
		state_d = state_q;
		pc_d    = pc_q;
		ph_d    = ph_q;
		if (state_q == S_PT || state_q == S_OUT) begin
			unique case (ph_q)
				PH_LO:   ph_d = PH_HI;
				PH_HI:   ph_d = PH_WB;
				default: ph_d = PH_LO;
			endcase
		end
		unique case (state_q)
			S_IDLE: begin
				if (in_take && in_pt) begin
					state_d = S_PT;
					pc_d    = PC_PT_BEGIN;
					ph_d    = PH_LO;
				end else if (in_take && in_last) begin
					state_d = S_WAIT_OUT;
				end
			end
			S_PT: begin
				if (step_end) begin
					if (pc_q == PC_PT_END) begin
						state_d = last_q ? S_WAIT_OUT : S_IDLE;
					end else begin
						pc_d = pc_q + 6'd1;
					end
				end
			end
			S_WAIT_OUT: begin
				if (!out_busy) begin
					state_d = S_OUT;
					pc_d    = PC_OUT_BEGIN;
					ph_d    = PH_LO;
				end
			end
			S_OUT: begin
				if (step_end) begin
					if (pc_q == PC_OUT_END) begin
						state_d = S_IDLE;
					end else begin
						pc_d = pc_q + 6'd1;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Control outputs.
	always_comb begin
		ctl.ready = (state_q == S_IDLE);
		ctl.run   = (state_q == S_PT) || (state_q == S_OUT);
		ctl.ph    = ph_q;
		ctl.pc    = pc_q;
		ctl.fin   = (state_q == S_OUT) && step_end && (pc_q == PC_OUT_END);
	end

endmodule

@@ rtl/virtual_wrench_accumulator.sv @@
`timescale 1ns / 1ps
// Channel   Direction  Handshake            Payload
// in        receive    in_valid / in_stall    vwa_in_t: load or point item
// out       send       out_valid / out_stall  vwa_out_t: scaled force and torque
// cfg       receive    cfg_we                 cfg_index, cfg_data
//
// A load item or a skipped point needs no multiply steps. A valid point runs 33
// multiply steps on the single shared 33x32 multiplier. An item with last then
// waits until the output register is free and computes the six output products.
// Reset restores the identity
// transform, unit gains and zero sums at once; there is no clearing pass.
// in_stall is high while a step sequence runs or waits for the output register;
// out_stall only delays the output products of the next batch.

module virtual_wrench_accumulator #(
	parameter int unsigned FRAC_BITS = vwa_pkg::FRAC_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  vwa_pkg::vwa_in_t in_data,
	output logic             out_valid,
	input  logic             out_stall,
	output vwa_pkg::vwa_out_t out_data,
	input  logic             cfg_we,
	input  logic [2:0]       cfg_index,
	input  logic [31:0]      cfg_data
);
	import vwa_pkg::*;

	localparam logic signed [31:0] ONE_Q = 32'sd1 <<< FRAC_BITS;

	ctl_t               ctl;
	step_t              step;
	logic               in_take;
	logic               out_valid_q;
	vwa_out_t           out_q;

	logic signed [31:0] coeff_q [COEF_COUNT];
	logic signed [31:0] tmp_q [9];
	logic signed [31:0] ns_q [3];
	logic signed [31:0] pn_q [5];
	logic signed [63:0] sum_q [6];
	logic signed [31:0] stiff_q;
	logic signed [31:0] nscale_q;
	logic signed [31:0] scale_q [6];
	logic signed [65:0] acc_q;

	logic [4:0]         a_off_tmp, a_off_sum, b_off_ns, b_off_scale;
	logic signed [63:0] a_val;
	logic signed [31:0] b_val;
	logic signed [95:0] prod;
	logic signed [95:0] q_full;
	logic signed [65:0] q66;
	logic signed [65:0] acc_next;
	logic signed [65:0] sum_next;
	logic               wb;

	assign in_take   = in_valid && !in_stall;
	assign in_stall  = !ctl.ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign step      = vwa_step(ctl.pc);
	assign wb        = ctl.run && (ctl.ph == PH_WB);

	vwa_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_take  (in_take),
		.in_pt    (in_data.cmd == CMD_POINT && in_data.point_valid),
		.in_last  (in_data.last),
		.out_busy (out_valid_q && out_stall),
		.ctl      (ctl)
	);

	vwa_mul u_mul (
		.clk  (clk),
		.ph   (ctl.ph),
		.a    (a_val),
		.b    (b_val),
		.prod (prod)
	);

	// Operand selection for the shared multiplier.
	assign a_off_tmp   = step.a_src - 5'(A_TMP0);
	assign a_off_sum   = step.a_src - 5'(A_SUM0);
	assign b_off_ns    = step.b_src - 5'(B_NS0);
	assign b_off_scale = step.b_src - 5'(B_SCALE0);

	always_comb begin
		if (step.a_src < 5'(A_TMP0)) begin
			a_val = 64'(coeff_q[step.a_src[3:0]]);
		end else if (step.a_src < 5'(A_SUM0)) begin
			a_val = 64'(tmp_q[a_off_tmp[3:0]]);
		end else begin
			a_val = sum_q[a_off_sum[2:0]];
		end
	end

	always_comb begin
		if (step.b_src < 5'(B_NS0)) begin
			b_val = pn_q[step.b_src[2:0]];
		end else if (step.b_src < 5'(B_STIFF)) begin
			b_val = ns_q[b_off_ns[1:0]];
		end else if (step.b_src == 5'(B_STIFF)) begin
			b_val = stiff_q;
		end else if (step.b_src == 5'(B_NSCALE)) begin
			b_val = nscale_q;
		end else if (step.b_src == 5'(B_ONE)) begin
			b_val = ONE_Q;
		end else begin
			b_val = scale_q[b_off_scale[2:0]];
		end
	end

	// Floor shift of the exact product and the two accumulations.
	assign q_full   = prod >>> FRAC_BITS;
	assign q66      = q_full[65:0];
	assign acc_next = (step.clr ? 66'sd0 : acc_q) + (step.neg ? -q66 : q66);
	assign sum_next = 66'(sum_q[step.dst[2:0]]) + q66;

	// Configuration registers and transform coefficients.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stiff_q  <= ONE_Q;
			nscale_q <= ONE_Q;
			for (int i = 0; i < 6; i++) begin
				scale_q[i] <= ONE_Q;
			end
			for (int i = 0; i < COEF_COUNT; i++) begin
				coeff_q[i] <= (i == 0 || i == 4 || i == 8) ? ONE_Q : 32'sd0;
			end
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_STIFFNESS:    stiff_q <= cfg_data;
					REG_NORMAL_SCALE: nscale_q <= cfg_data;
					default:          scale_q[3'(cfg_index - REG_SCALE_FIRST)] <= cfg_data;
				endcase
			end
			if (in_take && in_data.cmd == CMD_LOAD &&
			    in_data.coeff_index < 4'(COEF_COUNT)) begin
				coeff_q[in_data.coeff_index] <= in_data.coeff_value;
			end
		end
	end

	// Force and torque sums, cleared once the wrench is produced.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++) begin
				sum_q[i] <= 64'sd0;
			end
		end else if (ctl.fin) begin
			for (int i = 0; i < 6; i++) begin
				sum_q[i] <= 64'sd0;
			end
		end else if (wb && step.md == MD_SUM) begin
			sum_q[step.dst[2:0]] <= sat64(sum_next);
		end
	end

	// Point capture and per-step write-back of intermediate values.
	always_ff @(posedge clk) begin
		if (in_take) begin
			pn_q[0] <= in_data.point_x;
			pn_q[1] <= in_data.point_y;
			pn_q[2] <= in_data.point_z;
			pn_q[3] <= in_data.nrm_x;
			pn_q[4] <= in_data.nrm_y;
		end
		if (wb) begin
			unique case (step.md)
				MD_ROW: begin
					acc_q <= acc_next;
					if (step.wr) begin
						tmp_q[step.dst] <= sat32(acc_next);
					end
				end
				MD_SCALE: ns_q[step.dst[1:0]] <= sat32(q66);
				MD_OUT: begin
					unique case (step.dst[2:0])
						3'd0:    out_q.force_x  <= sat48(q_full);
						3'd1:    out_q.force_y  <= sat48(q_full);
						3'd2:    out_q.force_z  <= sat48(q_full);
						3'd3:    out_q.torque_x <= sat48(q_full);
						3'd4:    out_q.torque_y <= sat48(q_full);
						default: out_q.torque_z <= sat48(q_full);
					endcase
				end
				default: ;
			endcase
		end
	end

	// Output beat valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.fin) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

@@ rtl/vwa_checker.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"

module vwa_sva (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_stall,
	input vwa_pkg::vwa_in_t  in_data,
	input logic              out_valid,
	input logic              out_stall,
	input vwa_pkg::vwa_out_t out_data
);
	import vwa_pkg::*;

	// A stalled output beat stays valid.
	`VWA_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid, "out beat dropped while stalled")

	// A stalled output beat keeps its payload.
	`VWA_ASSERT_SAME(a_out_stable, clk, arst_n, out_valid && $past(out_valid) && $past(out_stall), out_data == $past(out_data), "out payload changed while stalled")

	// A valid point keeps the block busy in the following cycle.
	`VWA_ASSERT_NEXT(a_point_busy, clk, arst_n, in_valid && !in_stall && in_data.cmd == CMD_POINT && in_data.point_valid, in_stall, "valid point did not start the step sequence")

	// The output products need a full step sequence, so a taken beat is never followed at once.
	`VWA_ASSERT_NEXT(a_no_repeat, clk, arst_n, out_valid && !out_stall, !out_valid, "result beat repeated")

endmodule

bind virtual_wrench_accumulator vwa_sva u_vwa_checker (.*);

@@ verif/vwa_checker.sv @@
`timescale 1ns / 1ps

module vwa_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_stall,
	input  vwa_pkg::vwa_in_t  in_data,
	input  logic              out_valid,
	input  logic              out_stall,
	input  vwa_pkg::vwa_out_t out_data,
	input  logic              cfg_we,
	input  logic [2:0]        cfg_index,
	input  logic [31:0]       cfg_data,
	output int                fail_count,
	output int                pending
);
	import vwa_pkg::*;

	localparam int FB = FRAC_BITS_DEF;

	// Shadow state of the accumulator.
	logic signed [31:0] stiff_q, nscale_q;
	logic signed [31:0] fscale_q [3];
	logic signed [31:0] tscale_q [3];
	logic signed [31:0] xform_q [12];
	logic signed [63:0] fsum_q [3];
	logic signed [63:0] tsum_q [3];
	vwa_out_t wrench_fifo [$];

	assign pending = wrench_fifo.size();

	// Clamp a wide signed value to w bits.
	function automatic logic signed [127:0] clamp_w(input logic signed [127:0] v, input int w);
		logic signed [127:0] hi, lo;
		hi = (128'sd1 <<< (w - 1)) - 1;
		lo = -hi - 1;
		return (v > hi) ? hi : ((v < lo) ? lo : v);
	endfunction

	// Exact product, floored by the fraction bits, saturated to w bits.
	function automatic logic signed [127:0] qmul(input logic signed [127:0] a,
			input logic signed [127:0] b, input int w);
		logic signed [127:0] p;
		p = (a * b) >>> FB;
		return clamp_w(p, w);
	endfunction

	function automatic logic signed [127:0] add64(input logic signed [127:0] a,
			input logic signed [127:0] b);
		return clamp_w(a + b, 64);
	endfunction

	task automatic report(input string what, input logic [47:0] got, input logic [47:0] exp);
		$display("%0t mismatch on %s: got %h expected %h", $realtime, what, got, exp);
		fail_count++;
	endtask

	// Apply one accepted beat to the shadow state.
	task automatic apply_item(input vwa_in_t it);
		logic signed [127:0] pv [3], nv [3], pt [3], nt [3], ns [3], cr [3], acc;
		vwa_out_t w;
		int a, b;
		if (it.cmd == CMD_LOAD) begin
			if (it.coeff_index < COEF_COUNT) xform_q[it.coeff_index] = it.coeff_value;
		end else if (it.point_valid) begin
			pv[0] = it.point_x; pv[1] = it.point_y; pv[2] = it.point_z;
			nv[0] = it.nrm_x; nv[1] = it.nrm_y; nv[2] = 0;
			for (int i = 0; i < 3; i++) begin
				acc = xform_q[9 + i];
				for (int j = 0; j < 3; j++) acc = add64(acc, qmul(xform_q[3*i+j], pv[j], 64));
				pt[i] = clamp_w(acc, 32);
				acc = 0;
				for (int j = 0; j < 3; j++) acc = add64(acc, qmul(xform_q[3*i+j], nv[j], 64));
				nt[i] = clamp_w(acc, 32);
			end
			for (int i = 0; i < 3; i++) ns[i] = qmul(nt[i], nscale_q, 32);
			for (int i = 0; i < 3; i++) begin
				a = (i + 1) % 3;
				b = (i + 2) % 3;
				cr[i] = clamp_w(add64(qmul(pt[a], ns[b], 64), -qmul(pt[b], ns[a], 64)), 32);
			end
			for (int i = 0; i < 3; i++) begin
				fsum_q[i] = 64'(add64(fsum_q[i], qmul(pt[i], stiff_q, 64)));
				tsum_q[i] = 64'(add64(tsum_q[i], qmul(cr[i], stiff_q, 64)));
			end
		end
		if (it.last) begin
			w.force_x  = 48'(qmul(fsum_q[0], fscale_q[0], 48));
			w.force_y  = 48'(qmul(fsum_q[1], fscale_q[1], 48));
			w.force_z  = 48'(qmul(fsum_q[2], fscale_q[2], 48));
			w.torque_x = 48'(qmul(tsum_q[0], tscale_q[0], 48));
			w.torque_y = 48'(qmul(tsum_q[1], tscale_q[1], 48));
			w.torque_z = 48'(qmul(tsum_q[2], tscale_q[2], 48));
			wrench_fifo.push_back(w);
			for (int i = 0; i < 3; i++) begin
				fsum_q[i] = 0;
				tsum_q[i] = 0;
			end
		end
	endtask

	// Compare one output beat with the oldest expected wrench.
	task automatic check_wrench(input vwa_out_t got);
		vwa_out_t exp;
		if (wrench_fifo.size() == 0) begin
			report("unexpected beat", got.force_x, 48'd0);
			return;
		end
		exp = wrench_fifo.pop_front();
		if (got.force_x !== exp.force_x) report("force_x", got.force_x, exp.force_x);
		if (got.force_y !== exp.force_y) report("force_y", got.force_y, exp.force_y);
		if (got.force_z !== exp.force_z) report("force_z", got.force_z, exp.force_z);
		if (got.torque_x !== exp.torque_x) report("torque_x", got.torque_x, exp.torque_x);
		if (got.torque_y !== exp.torque_y) report("torque_y", got.torque_y, exp.torque_y);
		if (got.torque_z !== exp.torque_z) report("torque_z", got.torque_z, exp.torque_z);
	endtask

	// Track reset, register writes and both channels at the rising edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fail_count = 0;
			stiff_q = 32'sd1 <<< FB;
			nscale_q = 32'sd1 <<< FB;
			for (int i = 0; i < 3; i++) begin
				fscale_q[i] = 32'sd1 <<< FB;
				tscale_q[i] = 32'sd1 <<< FB;
				fsum_q[i] = 0;
				tsum_q[i] = 0;
			end
			for (int i = 0; i < 12; i++) xform_q[i] = 0;
			xform_q[0] = 32'sd1 <<< FB;
			xform_q[4] = 32'sd1 <<< FB;
			xform_q[8] = 32'sd1 <<< FB;
			wrench_fifo.delete();
		end else begin
			if (out_valid && !out_stall) check_wrench(out_data);
			if (cfg_we) begin
				if (cfg_index == REG_STIFFNESS) stiff_q = cfg_data;
				else if (cfg_index == REG_NORMAL_SCALE) nscale_q = cfg_data;
				else if (cfg_index < REG_SCALE_FIRST + 3)
					fscale_q[2'(cfg_index - REG_SCALE_FIRST)] = cfg_data;
				else tscale_q[2'(cfg_index - REG_SCALE_FIRST - 3)] = cfg_data;
			end
			if (in_valid && !in_stall) apply_item(in_data);
		end
	end

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
	import vwa_pkg::*;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     in_valid = 1'b0;
	logic     in_stall;
	vwa_in_t  in_data = '0;
	logic     out_valid;
	logic     out_stall = 1'b0;
	vwa_out_t out_data;
	logic     cfg_we = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [31:0] cfg_data = '0;
	int       fail_count;
	int       pending;
	int       hold_cycles = 0;

	localparam int ONE = 1 << FRAC_BITS_DEF;

	virtual_wrench_accumulator u_top (.*);

	vwa_checker u_chk (.*);

	always #10 clk = ~clk;

	initial begin
		#50ms;
		$display("virtual_wrench_accumulator verification failed");
		$finish;
	end

	// Receiver: random stalls, plus a long hold-off when requested.
	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				out_stall <= 1'b1;
				hold_cycles--;
			end else begin
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
				if ($urandom_range(0, 2) == 0) gap = 0;
				if (gap != 0) begin
					out_stall <= 1'b1;
					repeat (gap) begin
						@(negedge clk);
						if (hold_cycles > 0) hold_cycles--;
					end
				end
				out_stall <= 1'b0;
			end
		end
	end

	function automatic logic [31:0] rand_q();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return $urandom();
			default: return $signed($urandom_range(0, 8 * ONE)) - 4 * ONE;
		endcase
	endfunction

	// Present one beat and return at the edge that accepts it; valid stays up.
	task automatic send_beat(input vwa_in_t it, input int max_gap);
		int gap;
		gap = (max_gap == 0) ? 0 : $urandom_range(0, max_gap);
		@(negedge clk);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_data <= it;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
	endtask

	// Drop valid after the last accepted beat.
	task automatic release_in();
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	task automatic load_coeff(input int idx, input logic [31:0] v, input bit lst, input int g);
		vwa_in_t it;
		it = '0;
		it.cmd = CMD_LOAD;
		it.coeff_index = 4'(idx);
		it.coeff_value = v;
		it.last = lst;
		send_beat(it, g);
	endtask

	task automatic send_point(input bit ok, input bit lst, input int g);
		vwa_in_t it;
		it.cmd = CMD_POINT;
		it.coeff_index = 4'($urandom());
		it.coeff_value = $urandom();
		it.point_x = rand_q();
		it.point_y = rand_q();
		it.point_z = rand_q();
		it.nrm_x = rand_q();
		it.nrm_y = rand_q();
		it.point_valid = ok;
		it.last = lst;
		send_beat(it, g);
	endtask

	// Wait for every wrench to arrive, then let the block settle.
	task automatic drain();
		release_in();
		while (pending != 0) @(negedge clk);
		repeat (150) @(negedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// One batch of random content; mostly sane transforms and points.
	task automatic random_batch(input int n);
		for (int k = 0; k < n; k++) begin
			if ($urandom_range(0, 5) == 0)
				load_coeff($urandom_range(0, 15), rand_q(), k == n - 1, 16);
			else
				send_point($urandom_range(0, 6) != 0, k == n - 1, 16);
		end
	endtask

	initial begin
		int sent;
		int n;
		logic [31:0] corner [4];
		corner[0] = ONE;
		corner[1] = 32'h8000_0000;
		corner[2] = 32'h7fff_ffff;
		corner[3] = 32'hffff_0000;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: default transform, corners, skipped and out-of-range loads.
		send_point(1'b1, 1'b0, 0);
		send_point(1'b0, 1'b1, 0);
		load_coeff(9, 32'h7fff_ffff, 1'b0, 0);
		load_coeff(1, 32'h8000_0000, 1'b0, 0);
		load_coeff(13, 32'h1234_5678, 1'b0, 0);
		send_point(1'b1, 1'b1, 0);
		load_coeff(2, ONE, 1'b1, 0);
		for (int k = 0; k < 6; k++) send_point(1'b1, k == 5, 0);
		for (int i = 0; i < 12; i++) load_coeff(i, (i % 4 == 0) ? ONE : 0, 1'b0, 0);
		load_coeff(15, 0, 1'b1, 0);
		sent = 26;
		drain();

		// Register settings: extremes, then random ones between phases.
		for (int ph = 0; ph < 8; ph++) begin
			for (int r = 0; r < 8; r++)
				write_reg(3'(r), (ph < 4) ? corner[ph] :
					(($urandom_range(0, 1) != 0) ? ONE : rand_q()));
			if (ph == 2) begin
				// Hold the output so the block backs up into the input.
				hold_cycles = 1500;
				for (int k = 0; k < 12; k++) send_point(1'b1, k % 3 == 2, 0);
				sent += 12;
			end
			while (sent < 25 + 180 * (ph + 1)) begin
				n = $urandom_range(1, 8);
				random_batch(n);
				sent += n;
				if ($urandom_range(0, 15) == 0) begin
					release_in();
					while (pending != 0) @(negedge clk);
				end
			end
			drain();
		end
		drain();
		if (fail_count == 0) begin
			$display("virtual_wrench_accumulator verification clean");
		end else begin
			$display("virtual_wrench_accumulator verification failed");
		end
		$finish;
	end

endmodule

@@ virtual_wrench_accumulator.f @@
+incdir+rtl
rtl/vwa_pkg.sv
rtl/vwa_mul.sv
rtl/vwa_seq.sv
rtl/virtual_wrench_accumulator.sv
rtl/vwa_checker.sv
verif/vwa_checker.sv
verif/tb_top.sv
